### design/led_bar_graph_renderer_assert.svh
// ----------------------------------------------------------------------------
// led bar graph renderer assertion macros
// concurrent checks clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LED_BAR_GRAPH_RENDERER_ASSERT_SVH
`define LED_BAR_GRAPH_RENDERER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge
`define LBGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be true at a clock edge
`define LBGR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LBGR_ASSERT(lbl, prop, msg)
`define LBGR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### design/lbgr_pkg.sv
// ----------------------------------------------------------------------------
// lbgr_pkg
// shared types, constants and the brightness correction table
// ----------------------------------------------------------------------------
package lbgr_pkg;

	localparam int LEN_W   = 6;
	localparam int CH_W    = 8;
	localparam int BRT_W   = 7;
	localparam int COLOR_W = 24;
	localparam int LIT_W   = 7;
	localparam int PROD_W  = CH_W + BRT_W;

	// strip select codes
	localparam logic [1:0] SEL_MAIN   = 2'd1;
	localparam logic [1:0] SEL_SECOND = 2'd2;

	localparam logic [CH_W-1:0]  ACTIVE_LEVEL      = 8'd25;
	localparam logic [LEN_W-1:0] DEFAULT_MAIN_LEDS = 6'd10;
	localparam logic [LEN_W-1:0] MAIN_LEN_RESET    = 6'd10;
	localparam int               FULL_PERCENT      = 100;

	// divide by 100: floor(p * 5243 / 2^19) is exact for p below 2^15
	localparam int                DIV_SHIFT = 19;
	localparam int                DIV_MUL_W = 28;
	localparam logic [12:0]       DIV_MUL   = 13'd5243;

	// one queued bar command after classification
	typedef struct packed {
		logic [LEN_W-1:0]   start;
		logic [LEN_W-1:0]   len;
		logic [LEN_W-1:0]   nlit;
		logic [COLOR_W-1:0] on_color;
		logic [BRT_W-1:0]   on_brt;
		logic [COLOR_W-1:0] off_color;
		logic [BRT_W-1:0]   off_brt;
		logic               show;
	} cmd_t;

	// row 0: two active channels, row 1: three active channels
	typedef logic [1:0][(1<<BRT_W)-1:0][BRT_W-1:0] corr_tbl_t;

	// largest k with n*k*k <= b*b, clamped to 1..100
	function automatic corr_tbl_t build_corr_tbl();
		corr_tbl_t t;
		int n;
		int k;
		for (int r = 0; r < 2; r++) begin
			n = r + 2;
			for (int b = 0; b < (1 << BRT_W); b++) begin
				k = 0;
				while (k < b && n * (k + 1) * (k + 1) <= b * b) k++;
				if (k < 1) k = 1;
				if (k > FULL_PERCENT) k = FULL_PERCENT;
				t[r][b] = BRT_W'(k);
			end
		end
		return t;
	endfunction

	localparam corr_tbl_t CORR_TBL = build_corr_tbl();

	// corrected brightness for a color with act active channels
	// a dark color passes b through, one channel only clamps to 1..100
	function automatic logic [BRT_W-1:0] corrected_brt(logic [1:0] act,
			logic [BRT_W-1:0] b);
		logic [BRT_W-1:0] res;
		case (act)
			2'd0: begin
				res = b;
			end
			2'd1: begin
				if (b == '0) begin
					res = BRT_W'(1);
				end else if (b > BRT_W'(FULL_PERCENT)) begin
					res = BRT_W'(FULL_PERCENT);
				end else begin
					res = b;
				end
			end
			2'd2: begin
				res = CORR_TBL[0][b];
			end
			default: begin
				res = CORR_TBL[1][b];
			end
		endcase
		return res;
	endfunction

endpackage

### design/lbgr_front.sv
// ----------------------------------------------------------------------------
// lbgr_front
// holds the strip length register, takes bar commands and classifies them
// ----------------------------------------------------------------------------
module lbgr_front import lbgr_pkg::*; #(
	parameter int SECOND_STRIP_LEDS = 10,
	parameter int MAIN_STRIP_MAX    = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEN_W-1:0]    cfg_data,
	input  logic                accept,
	input  logic [1:0]          strip_select,
	input  logic [LIT_W-1:0]    lit_count,
	input  logic [COLOR_W-1:0]  on_color,
	input  logic [BRT_W-1:0]    on_brightness,
	input  logic [COLOR_W-1:0]  off_color,
	input  logic [BRT_W-1:0]    off_brightness,
	input  logic                show_now,
	output logic                cmd_wr,
	output cmd_t                cmd_data
);

	logic [LEN_W-1:0] main_len_q;
	logic [LEN_W-1:0] main_eff;
	logic [LEN_W-1:0] start;
	logic [LEN_W-1:0] len;
	logic             sel_ok;
	logic [LEN_W-1:0] nlit;
	logic [1:0]       on_act;
	logic [1:0]       off_act;

	assign cfg_ready = 1'b1;

	// strip length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_len_q <= MAIN_LEN_RESET;
		end else if (cfg_valid) begin
			main_len_q <= cfg_data;
		end
	end

	// effective main strip length: zero fallback first, then saturation
	always_comb begin
		main_eff = (main_len_q == '0) ? DEFAULT_MAIN_LEDS : main_len_q;
		if (32'(main_eff) > MAIN_STRIP_MAX) begin
			main_eff = LEN_W'(MAIN_STRIP_MAX);
		end
	end

	// strip placement
	always_comb begin
		sel_ok = 1'b1;
		start  = '0;
		len    = main_eff;
		case (strip_select)
			SEL_MAIN: begin
				start = '0;
				len   = main_eff;
			end
			SEL_SECOND: begin
				start = main_eff;
				len   = LEN_W'(SECOND_STRIP_LEDS);
			end
			default: begin
				sel_ok = 1'b0;
			end
		endcase
	end

	// lit count saturation to the strip length; counts of 64 and up give zero
	always_comb begin
		if (lit_count[LIT_W-1]) begin
			nlit = '0;
		end else if (lit_count[LEN_W-1:0] > len) begin
			nlit = len;
		end else begin
			nlit = lit_count[LEN_W-1:0];
		end
	end

	// active channel counts
	assign on_act  = 2'(on_color[23:16] > ACTIVE_LEVEL) + 2'(on_color[15:8] > ACTIVE_LEVEL)
		+ 2'(on_color[7:0] > ACTIVE_LEVEL);
	assign off_act = 2'(off_color[23:16] > ACTIVE_LEVEL) + 2'(off_color[15:8] > ACTIVE_LEVEL)
		+ 2'(off_color[7:0] > ACTIVE_LEVEL);

	// classified command; invalid strips are dropped here
	assign cmd_wr             = accept && sel_ok;
	assign cmd_data.start     = start;
	assign cmd_data.len       = len;
	assign cmd_data.nlit      = nlit;
	assign cmd_data.on_color  = on_color;
	assign cmd_data.on_brt    = corrected_brt(on_act, on_brightness);
	assign cmd_data.off_color = off_color;
	assign cmd_data.off_brt   = corrected_brt(off_act, off_brightness);
	assign cmd_data.show      = show_now;

endmodule

### design/lbgr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lbgr_cmd_fifo
// two-entry command queue between the front and the pixel sequencer
// ----------------------------------------------------------------------------
module lbgr_cmd_fifo import lbgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

### design/lbgr_back.sv
// ----------------------------------------------------------------------------
// lbgr_back
// steps the head command one pixel a cycle if results fit; dims, queues them
// ----------------------------------------------------------------------------
module lbgr_back import lbgr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic [LEN_W-1:0] pixel_index,
	output logic [CH_W-1:0]  red_level,
	output logic [CH_W-1:0]  green_level,
	output logic [CH_W-1:0]  blue_level,
	output logic             refresh,
	output logic             last_pixel
);

	`include "led_bar_graph_renderer_assert.svh"

	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [LEN_W-1:0] index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             refresh;
		logic             last;
	} pix_t;

	logic [LEN_W-1:0]   idx_q;
	logic               issue;
	logic               is_last;
	logic               use_on;
	logic [COLOR_W-1:0] color;
	logic [BRT_W-1:0]   brt;

	logic               v_s1;
	logic [LEN_W-1:0]   index_s1;
	logic               last_s1;
	logic               refresh_s1;
	logic [PROD_W-1:0]  r_prod_s1;
	logic [PROD_W-1:0]  g_prod_s1;
	logic [PROD_W-1:0]  b_prod_s1;

	logic [DIV_MUL_W-1:0] r_scaled;
	logic [DIV_MUL_W-1:0] g_scaled;
	logic [DIV_MUL_W-1:0] b_scaled;
	pix_t                 pix_in;

	pix_t       out_q [OUT_DEPTH];
	logic [1:0] out_wr_q;
	logic [1:0] out_rd_q;
	logic [2:0] out_cnt_q;
	logic       out_pop;

	// issue a pixel while the result queue has room for it
	assign issue   = !cmd_empty && ((4'(out_cnt_q) + 4'(v_s1)) < 4'(OUT_DEPTH));
	assign is_last = (idx_q == cmd.len - LEN_W'(1));
	assign cmd_pop = issue && is_last;

	// pixel counter within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= is_last ? '0 : idx_q + LEN_W'(1);
		end
	end

	// on or off color for this pixel
	assign use_on = (idx_q < cmd.nlit);
	assign color  = use_on ? cmd.on_color : cmd.off_color;
	assign brt    = use_on ? cmd.on_brt : cmd.off_brt;

	// stage 1: channel times brightness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			index_s1   <= cmd.start + idx_q;
			last_s1    <= is_last;
			refresh_s1 <= is_last && cmd.show;
			r_prod_s1  <= PROD_W'(color[23:16]) * PROD_W'(brt);
			g_prod_s1  <= PROD_W'(color[15:8]) * PROD_W'(brt);
			b_prod_s1  <= PROD_W'(color[7:0]) * PROD_W'(brt);
		end
	end

	// divide by 100 through the reciprocal
	assign r_scaled = DIV_MUL_W'(r_prod_s1) * DIV_MUL_W'(DIV_MUL);
	assign g_scaled = DIV_MUL_W'(g_prod_s1) * DIV_MUL_W'(DIV_MUL);
	assign b_scaled = DIV_MUL_W'(b_prod_s1) * DIV_MUL_W'(DIV_MUL);

	assign pix_in.index   = index_s1;
	assign pix_in.red     = r_scaled[DIV_SHIFT +: CH_W];
	assign pix_in.green   = g_scaled[DIV_SHIFT +: CH_W];
	assign pix_in.blue    = b_scaled[DIV_SHIFT +: CH_W];
	assign pix_in.refresh = refresh_s1;
	assign pix_in.last    = last_s1;

	// result queue storage
	always_ff @(posedge clk) begin
		if (v_s1) begin
			out_q[out_wr_q] <= pix_in;
		end
	end

	assign out_pop = pop && !empty;

	// result queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (v_s1) out_wr_q <= out_wr_q + 2'd1;
			if (out_pop) out_rd_q <= out_rd_q + 2'd1;
			out_cnt_q <= out_cnt_q + 3'(v_s1) - 3'(out_pop);
		end
	end

	// result ports
	assign empty       = (out_cnt_q == 3'd0);
	assign pixel_index = out_q[out_rd_q].index;
	assign red_level   = out_q[out_rd_q].red;
	assign green_level = out_q[out_rd_q].green;
	assign blue_level  = out_q[out_rd_q].blue;
	assign refresh     = out_q[out_rd_q].refresh;
	assign last_pixel  = out_q[out_rd_q].last;

	// checks
	`LBGR_ASSERT_NEVER(a_out_credit, (4'(out_cnt_q) + 4'(v_s1)) > 4'(OUT_DEPTH), "result queue overrun")
	`LBGR_ASSERT_NEVER(a_idx_range, !cmd_empty && (idx_q >= cmd.len), "pixel counter past strip")
	`LBGR_ASSERT(a_s1_lands, v_s1 && !out_pop |=> out_cnt_q == $past(out_cnt_q) + 3'd1, "pixel lost")
	`LBGR_ASSERT(a_last_wraps, issue && is_last |=> idx_q == '0, "counter not cleared after run")

endmodule

### design/led_bar_graph_renderer.sv
// ----------------------------------------------------------------------------
// led_bar_graph_renderer
// turns bar-draw commands into per-LED dimmed pixel values
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// command   in         push / full            strip_select .. show_now
// pixel     out        empty / pop            pixel_index .. last_pixel
// config    in         cfg_valid / cfg_ready  cfg_data (main strip length)
//
// a command for a strip of L LEDs gives L pixels, one per cycle while pop
// keeps up; a pixel passes the command queue, stage 1 and the result queue.
// the pixel counter in the back end sets the rate; commands to an invalid
// strip are taken and give nothing. a two-deep command queue lets the
// next command in while a run is going. stalls on pop hold the result queue.
// reset sets the main strip length to 10 and empties both queues.
// ----------------------------------------------------------------------------
module led_bar_graph_renderer import lbgr_pkg::*; #(
	parameter int SECOND_STRIP_LEDS = 10,
	parameter int MAIN_STRIP_MAX    = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LEN_W-1:0]   cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         strip_select,
	input  logic [LIT_W-1:0]   lit_count,
	input  logic [COLOR_W-1:0] on_color,
	input  logic [BRT_W-1:0]   on_brightness,
	input  logic [COLOR_W-1:0] off_color,
	input  logic [BRT_W-1:0]   off_brightness,
	input  logic               show_now,
	output logic               empty,
	input  logic               pop,
	output logic [LEN_W-1:0]   pixel_index,
	output logic [CH_W-1:0]    red_level,
	output logic [CH_W-1:0]    green_level,
	output logic [CH_W-1:0]    blue_level,
	output logic               refresh,
	output logic               last_pixel
);

	logic accept;
	logic cmd_wr;
	cmd_t cmd_wdata;
	logic cmd_pop;
	cmd_t cmd_head;
	logic cmd_empty;

	assign accept = push && !full;

	// command classification
	lbgr_front #(
		.SECOND_STRIP_LEDS(SECOND_STRIP_LEDS),
		.MAIN_STRIP_MAX(MAIN_STRIP_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.accept(accept),
		.strip_select(strip_select),
		.lit_count(lit_count),
		.on_color(on_color),
		.on_brightness(on_brightness),
		.off_color(off_color),
		.off_brightness(off_brightness),
		.show_now(show_now),
		.cmd_wr(cmd_wr),
		.cmd_data(cmd_wdata)
	);

	// command queue
	lbgr_cmd_fifo u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_wr),
		.wr_data(cmd_wdata),
		.full(full),
		.rd_en(cmd_pop),
		.rd_data(cmd_head),
		.empty(cmd_empty)
	);

	// pixel sequencer and dimming
	lbgr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.pixel_index(pixel_index),
		.red_level(red_level),
		.green_level(green_level),
		.blue_level(blue_level),
		.refresh(refresh),
		.last_pixel(last_pixel)
	);

endmodule
